>>> src/tkk_pkg.sv
`timescale 1ns / 1ps
package tkk_pkg;

	localparam int CAPACITY  = 64;
	localparam int KEY_ITEMS = 4;

	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int PAY_W    = 64;
	localparam int SCORE_W  = 32;
	localparam int MAXREC_W = 7;
	localparam int TOL_W    = 17;
	localparam int HELD_W   = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [PAY_W-1:0] PAYLOAD_MASK = {PAY_W{1'b1}} >> (PAY_W - 16 * KEY_ITEMS);
	localparam logic [TOL_W-1:0] TOL_ONE = TOL_W'(65536);
	localparam logic [MAXREC_W-1:0] MAXREC_RST = MAXREC_W'(64);

	localparam logic [1:0] OP_OFFER  = 2'd0;
	localparam logic [1:0] OP_REWIND = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORDS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 1'b1;

	typedef struct packed {
		logic [PAY_W-1:0]          payload;
		logic signed [SCORE_W-1:0] score;
	} entry_t;

	typedef struct packed {
		logic                      accepted;
		logic                      read_valid;
		logic [PAY_W-1:0]          read_payload;
		logic signed [SCORE_W-1:0] read_score;
	} res_t;

endpackage

>>> src/tkk_if.sv
`timescale 1ns / 1ps
interface tkk_req_if;
	import tkk_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [1:0]                opcode;
	logic [PAY_W-1:0]          payload;
	logic signed [SCORE_W-1:0] score;
	logic                      score_valid;
	modport source (output valid, opcode, payload, score, score_valid, input ready);
	modport sink (input valid, opcode, payload, score, score_valid, output ready);
endinterface

interface tkk_rsp_if;
	import tkk_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      accepted;
	logic                      read_valid;
	logic [PAY_W-1:0]          read_payload;
	logic signed [SCORE_W-1:0] read_score;
	logic [HELD_W-1:0]         held_count;
	modport source (output valid, accepted, read_valid, read_payload, read_score,
		held_count, input ready);
	modport sink (input valid, accepted, read_valid, read_payload, read_score,
		held_count, output ready);
endinterface

interface tkk_cfg_if;
	import tkk_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [TOL_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> src/tkk_ram.sv
`timescale 1ns / 1ps
module tkk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> src/tkk_thresh.sv
`timescale 1ns / 1ps
module tkk_thresh (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic                              best_ok,
	input  logic signed [tkk_pkg::SCORE_W-1:0] best,
	input  logic [tkk_pkg::TOL_W-1:0]          tolerance,
	input  logic signed [tkk_pkg::SCORE_W-1:0] cand,
	output logic                              below
);
	import tkk_pkg::*;

	localparam int PROD_W = SCORE_W + TOL_W + 1;

	logic [TOL_W-1:0]         tol_sat;
	logic [TOL_W-1:0]         frac;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] rhs_q;
	logic signed [PROD_W-1:0] lhs;
	logic                     ok_q;

	// rhs = best * (1.0 - tol); candidate is below when cand * 1.0 < rhs
	always_comb begin
		tol_sat = (tolerance > TOL_ONE) ? TOL_ONE : tolerance;
		frac    = TOL_ONE - tol_sat;
		prod    = PROD_W'(best) * PROD_W'($signed({1'b0, frac}));
		lhs     = {{(PROD_W - SCORE_W - 16){cand[SCORE_W-1]}}, cand, 16'b0};
		below   = ok_q && (lhs < rhs_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
		end else if (load) begin
			ok_q  <= best_ok;
			rhs_q <= prod;
		end
	end
endmodule

>>> src/top_k_keeper_with_tolerance_top.sv
`timescale 1ns / 1ps
// channel | dir | fields                                                  | word
// req     | in  | opcode, payload, score, score_valid                     | one command
// rsp     | out | accepted, read_valid, read_payload, read_score, held_cnt | one result
// cfg     | in  | index (0 max_records, 1 tolerance), data                | one reg write
//
// One command at a time; req.ready is high only in idle. Rewind, nop, a read past the end
// and an offer with a bad score go straight to done; a read has read and capture states.
// An offer is first tested against the floor; a stored one walks up from the tail with a
// read and a compare state per entry shifted down (no compare when it lands at the head); a
// full store adds checks, tail floor tests and a drop unless that empties it. The list sits
// in a RAM with one registered read port; a stall on rsp holds a command in its last state
// until the previous word leaves. Async reset empties the store; no clearing pass.
module top_k_keeper_with_tolerance_top (
	input logic     clk,
	input logic     arst_n,
	tkk_req_if.sink req,
	tkk_rsp_if.source rsp,
	tkk_cfg_if.sink cfg
);
	import tkk_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE = 14'h0001,
		S_MUL  = 14'h0002,
		S_CHK  = 14'h0004,
		S_PCHK = 14'h0008,
		S_PRD  = 14'h0010,
		S_PEV  = 14'h0020,
		S_DCHK = 14'h0040,
		S_DRD  = 14'h0080,
		S_DEV  = 14'h0100,
		S_IRD  = 14'h0200,
		S_IEV  = 14'h0400,
		S_RRD  = 14'h0800,
		S_RCAP = 14'h1000,
		S_DONE = 14'h2000
	} st_t;

	st_t                       state_q;
	logic [MAXREC_W-1:0]       max_rec_q;
	logic [TOL_W-1:0]          tol_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          cursor_q;
	logic [CNT_W-1:0]          idx_q;
	logic [CNT_W-1:0]          count_m1;
	logic [CNT_W-1:0]          idx_m1;
	logic [CNT_W-1:0]          lim;
	logic                      best_ok_q;
	logic                      worst_ok_q;
	logic signed [SCORE_W-1:0] best_q;
	logic signed [SCORE_W-1:0] worst_q;
	entry_t                    new_q;
	res_t                      res_q;
	res_t                      rsp_q;
	logic [HELD_W-1:0]         held_q;
	logic                      rsp_valid_q;

	logic                      ram_we;
	logic [ADDR_W-1:0]         ram_waddr;
	logic [ADDR_W-1:0]         ram_raddr;
	entry_t                    ram_wdata;
	entry_t                    ram_rdata;

	logic                      th_load;
	logic signed [SCORE_W-1:0] th_cand;
	logic                      th_below;

	logic                      shift;
	logic                      ins_done;
	logic                      done_go;

	tkk_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	tkk_thresh u_thresh (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (th_load),
		.best_ok  (best_ok_q),
		.best     (best_q),
		.tolerance(tol_q),
		.cand     (th_cand),
		.below    (th_below)
	);

	always_comb begin
		count_m1 = count_q - 1'b1;
		idx_m1   = idx_q - 1'b1;
		if (max_rec_q == '0) begin
			lim = CNT_W'(1);
		end else if (max_rec_q > CAPACITY) begin
			lim = CNT_W'(CAPACITY);
		end else begin
			lim = CNT_W'(max_rec_q);
		end

		th_load = (state_q == S_MUL);
		case (state_q)
			S_CHK:   th_cand = new_q.score;
			S_PCHK:  th_cand = worst_q;
			default: th_cand = ram_rdata.score;
		endcase

		case (state_q)
			S_RRD:        ram_raddr = cursor_q[ADDR_W-1:0];
			S_PRD, S_DRD: ram_raddr = count_m1[ADDR_W-1:0];
			default:      ram_raddr = idx_m1[ADDR_W-1:0];
		endcase

		// walking up from the tail: entries scoring below the new one move down a slot
		shift     = (ram_rdata.score < new_q.score);
		ins_done  = ((state_q == S_IRD) && (idx_q == '0)) || ((state_q == S_IEV) && !shift);
		ram_we    = ((state_q == S_IRD) && (idx_q == '0)) || (state_q == S_IEV);
		ram_waddr = idx_q[ADDR_W-1:0];
		ram_wdata = ((state_q == S_IEV) && shift) ? ram_rdata : new_q;

		done_go = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			max_rec_q   <= MAXREC_RST;
			tol_q       <= '0;
			count_q     <= '0;
			cursor_q    <= '0;
			idx_q       <= '0;
			best_ok_q   <= 1'b0;
			worst_ok_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_MAX_RECORDS: max_rec_q <= cfg.data[MAXREC_W-1:0];
					CFG_TOLERANCE:   tol_q <= cfg.data;
					default:         ;
				endcase
			end

			if (done_go) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= res_q;
				held_q      <= HELD_W'(count_q);
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						res_q         <= '0;
						new_q.payload <= req.payload & PAYLOAD_MASK;
						new_q.score   <= req.score;
						case (req.opcode)
							OP_OFFER:  state_q <= req.score_valid ? S_MUL : S_DONE;
							OP_REWIND: begin
								cursor_q <= '0;
								state_q  <= S_DONE;
							end
							OP_READ:   state_q <= (cursor_q < count_q) ? S_RRD : S_DONE;
							default:   state_q <= S_DONE;
						endcase
					end
				end
				S_MUL: state_q <= S_CHK;
				S_CHK: begin
					if (th_below) begin
						state_q <= S_DONE;
					end else if (count_q >= lim) begin
						if (worst_ok_q && (new_q.score <= worst_q)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_PCHK;
						end
					end else begin
						idx_q   <= count_q;
						state_q <= S_IRD;
					end
				end
				S_PCHK: state_q <= (worst_ok_q && th_below) ? S_PRD : S_DCHK;
				S_PRD: begin
					if (count_q == '0) begin
						worst_ok_q <= 1'b0;
						state_q    <= S_DCHK;
					end else begin
						state_q <= S_PEV;
					end
				end
				S_PEV: begin
					if (th_below) begin
						count_q <= count_m1;
						state_q <= S_PRD;
					end else begin
						worst_q <= ram_rdata.score;
						state_q <= S_DCHK;
					end
				end
				S_DCHK: begin
					if (count_q >= lim) begin
						count_q <= count_m1;
						if (count_m1 == '0) begin
							best_ok_q  <= 1'b0;
							worst_ok_q <= 1'b0;
							idx_q      <= '0;
							state_q    <= S_IRD;
						end else begin
							state_q <= S_DRD;
						end
					end else begin
						idx_q   <= count_q;
						state_q <= S_IRD;
					end
				end
				S_DRD: state_q <= S_DEV;
				S_DEV: begin
					worst_q <= ram_rdata.score;
					idx_q   <= count_q;
					state_q <= S_IRD;
				end
				S_IRD: begin
					if (idx_q != '0) begin
						state_q <= S_IEV;
					end
				end
				S_IEV: begin
					if (shift) begin
						idx_q   <= idx_m1;
						state_q <= S_IRD;
					end
				end
				S_RRD: state_q <= S_RCAP;
				S_RCAP: begin
					res_q.read_valid   <= 1'b1;
					res_q.read_payload <= ram_rdata.payload;
					res_q.read_score   <= ram_rdata.score;
					cursor_q           <= cursor_q + 1'b1;
					state_q            <= S_DONE;
				end
				S_DONE: begin
					if (done_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (ins_done) begin
				count_q        <= count_q + 1'b1;
				res_q.accepted <= 1'b1;
				if (!best_ok_q || (new_q.score > best_q)) begin
					best_q    <= new_q.score;
					best_ok_q <= 1'b1;
				end
				if (!worst_ok_q || (new_q.score < worst_q)) begin
					worst_q    <= new_q.score;
					worst_ok_q <= 1'b1;
				end
				state_q <= S_DONE;
			end
		end
	end

	assign req.ready        = (state_q == S_IDLE);
	assign cfg.ready        = 1'b1;
	assign rsp.valid        = rsp_valid_q;
	assign rsp.accepted     = rsp_q.accepted;
	assign rsp.read_valid   = rsp_q.read_valid;
	assign rsp.read_payload = rsp_q.read_payload;
	assign rsp.read_score   = rsp_q.read_score;
	assign rsp.held_count   = held_q;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("held count above capacity");

	a_worst_needs_best: assert property (@(posedge clk) disable iff (!arst_n)
		worst_ok_q |-> best_ok_q)
		else $error("worst score known without best score");

	a_extrema_order: assert property (@(posedge clk) disable iff (!arst_n)
		(best_ok_q && worst_ok_q) |-> (best_q >= worst_q))
		else $error("worst score above best score");

	a_nonempty_worst: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> worst_ok_q)
		else $error("entries held but worst score invalid");
endmodule

>>> tb/sv/top_k_keeper_with_tolerance_checker.sv
`timescale 1ns / 1ps
module top_k_keeper_with_tolerance_checker
	import tkk_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	tkk_req_if   req,
	tkk_rsp_if   rsp,
	tkk_cfg_if   cfg,
	output int   fails,
	output int   pending,
	output int   words_checked,
	output int   offers_kept,
	output int   reads_hit,
	output int   purged,
	output int   dropped
);

	typedef struct packed {
		logic                      accepted;
		logic                      read_valid;
		logic [PAY_W-1:0]          read_payload;
		logic signed [SCORE_W-1:0] read_score;
		logic [HELD_W-1:0]         held_count;
	} outcome_t;

	// shadow copy of the sorted store, best first
	logic [PAY_W-1:0]          kp_pay [CAPACITY];
	logic signed [SCORE_W-1:0] kp_score [CAPACITY];
	int unsigned               kp_count;
	int unsigned               kp_cursor;
	bit                        hi_ok, lo_ok;
	logic signed [SCORE_W-1:0] hi_score, lo_score;
	logic [MAXREC_W-1:0]       lim_reg;
	logic [TOL_W-1:0]          tol_reg;

	outcome_t outcomes_due[$];
	int       word_seq;

	task automatic flag(input string msg);
		if (fails < 100)
			$display("mismatch at %0t, word %0d: %s", $time, word_seq, msg);
		fails++;
	endtask

	task automatic clear_keeper();
		kp_count  = 0;
		kp_cursor = 0;
		hi_ok     = 1'b0;
		lo_ok     = 1'b0;
		hi_score  = '0;
		lo_score  = '0;
		lim_reg   = MAXREC_RST;
		tol_reg   = '0;
		outcomes_due.delete();
	endtask

	function automatic int unsigned cur_limit();
		if (lim_reg == 0)
			return 1;
		if (lim_reg > CAPACITY)
			return CAPACITY;
		return lim_reg;
	endfunction

	// exact test of s < best * (1 - tol), tol saturated at 1.0
	function automatic bit under_floor(input logic signed [SCORE_W-1:0] s);
		longint t, lhs, rhs;
		if (!hi_ok)
			return 1'b0;
		t   = (tol_reg > TOL_ONE) ? longint'(TOL_ONE) : longint'(tol_reg);
		rhs = longint'(hi_score) * (longint'(TOL_ONE) - t);
		lhs = longint'(s) * longint'(TOL_ONE);
		return lhs < rhs;
	endfunction

	task automatic trim_below_floor();
		if (!lo_ok || !under_floor(lo_score))
			return;
		while (kp_count > 0 && under_floor(kp_score[kp_count - 1])) begin
			kp_count--;
			purged++;
		end
		// best score survives even an empty store here
		if (kp_count > 0)
			lo_score = kp_score[kp_count - 1];
		else
			lo_ok = 1'b0;
	endtask

	task automatic drop_last();
		if (kp_count == 0)
			return;
		kp_count--;
		dropped++;
		if (kp_count == 0) begin
			hi_ok = 1'b0;
			lo_ok = 1'b0;
		end else begin
			lo_score = kp_score[kp_count - 1];
		end
	endtask

	task automatic take_offer(input logic [PAY_W-1:0] pay, input logic signed [SCORE_W-1:0] s,
		input logic ok, output logic stored);
		int unsigned lim, pos, i;
		bit full;
		stored = 1'b0;
		lim = cur_limit();
		if (!ok || under_floor(s))
			return;
		full = kp_count >= lim;
		if (full && lo_ok && s <= lo_score)
			return;
		if (full)
			trim_below_floor();
		if (kp_count >= lim)
			drop_last();
		if (kp_count >= CAPACITY)
			return;
		// equal scores land behind the ones already held
		pos = 0;
		while (pos < kp_count && kp_score[pos] >= s)
			pos++;
		for (i = kp_count; i > pos; i--) begin
			kp_pay[i]   = kp_pay[i - 1];
			kp_score[i] = kp_score[i - 1];
		end
		kp_pay[pos]   = pay & PAYLOAD_MASK;
		kp_score[pos] = s;
		kp_count++;
		if (!hi_ok || s > hi_score) begin
			hi_score = s;
			hi_ok    = 1'b1;
		end
		if (!lo_ok || s < lo_score) begin
			lo_score = s;
			lo_ok    = 1'b1;
		end
		stored = 1'b1;
		offers_kept++;
	endtask

	task automatic keeper_step(input logic [1:0] op, input logic [PAY_W-1:0] pay,
		input logic signed [SCORE_W-1:0] s, input logic ok, output outcome_t o);
		logic stored;
		o = '0;
		case (op)
			OP_OFFER: begin
				take_offer(pay, s, ok, stored);
				o.accepted = stored;
			end
			OP_REWIND: begin
				kp_cursor = 0;
			end
			OP_READ: begin
				// past the end the cursor stays put
				if (kp_cursor < kp_count) begin
					o.read_valid   = 1'b1;
					o.read_payload = kp_pay[kp_cursor];
					o.read_score   = kp_score[kp_cursor];
					kp_cursor++;
					reads_hit++;
				end
			end
			default: ;
		endcase
		o.held_count = HELD_W'(kp_count);
	endtask

	task automatic check_word(input outcome_t got);
		outcome_t want;
		word_seq++;
		words_checked++;
		if (outcomes_due.size() == 0) begin
			flag("result word with nothing outstanding");
			return;
		end
		want = outcomes_due.pop_front();
		if (got.accepted !== want.accepted)
			flag($sformatf("accepted got %b want %b", got.accepted, want.accepted));
		if (got.read_valid !== want.read_valid)
			flag($sformatf("read_valid got %b want %b", got.read_valid, want.read_valid));
		if (got.read_payload !== want.read_payload)
			flag($sformatf("read_payload got %h want %h", got.read_payload, want.read_payload));
		if (got.read_score !== want.read_score)
			flag($sformatf("read_score got %0d want %0d", got.read_score, want.read_score));
		if (got.held_count !== want.held_count)
			flag($sformatf("held_count got %0d want %0d", got.held_count, want.held_count));
	endtask

	initial begin
		fails         = 0;
		pending       = 0;
		words_checked = 0;
		offers_kept   = 0;
		reads_hit     = 0;
		purged        = 0;
		dropped       = 0;
		word_seq      = 0;
		clear_keeper();
	end

	always @(posedge clk or negedge arst_n) begin
		outcome_t o;
		if (!arst_n) begin
			clear_keeper();
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_MAX_RECORDS)
					lim_reg = cfg.data[MAXREC_W-1:0];
				else if (cfg.index == CFG_TOLERANCE)
					tol_reg = cfg.data;
			end
			if (req.valid && req.ready) begin
				keeper_step(req.opcode, req.payload, req.score, req.score_valid, o);
				outcomes_due.push_back(o);
			end
			if (rsp.valid && rsp.ready)
				check_word({rsp.accepted, rsp.read_valid, rsp.read_payload, rsp.read_score,
					rsp.held_count});
		end
		pending = outcomes_due.size();
	end

endmodule

>>> tb/sv/top_k_keeper_with_tolerance_top_test.sv
`timescale 1ns / 1ps
module top_k_keeper_with_tolerance_top_test;
	import tkk_pkg::*;

	localparam int PHASES    = 12;
	localparam int PER_PHASE = 100;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	tkk_req_if req ();
	tkk_rsp_if rsp ();
	tkk_cfg_if cfg ();

	int fails, pending, words_checked, offers_kept, reads_hit, purged, dropped;
	int n_items    = 0;
	int n_settings = 0;
	bit calm       = 1'b0;
	logic signed [SCORE_W-1:0] last_score = '0;

	top_k_keeper_with_tolerance_top DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cfg   (cfg)
	);

	top_k_keeper_with_tolerance_checker watch (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.rsp          (rsp),
		.cfg          (cfg),
		.fails        (fails),
		.pending      (pending),
		.words_checked(words_checked),
		.offers_kept  (offers_kept),
		.reads_hit    (reads_hit),
		.purged       (purged),
		.dropped      (dropped)
	);

	always #5 clk = ~clk;

	initial begin
		#15_000_000;
		$display("status: fail");
		$finish;
	end

	// result side: ready runs with short stalls, a few long stalls, some long open stretches
	initial begin : rsp_side
		int r, len;
		bit go;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				go  = 1'b1;
				len = $urandom_range(100, 300);
			end else if (r < 65) begin
				go  = 1'b1;
				len = $urandom_range(1, 12);
			end else if (r < 95) begin
				go  = 1'b0;
				len = $urandom_range(1, 3);
			end else begin
				go  = 1'b0;
				len = $urandom_range(15, 40);
			end
			rsp.ready <= go;
			repeat (len) @(posedge clk);
		end
	end

	function automatic logic [PAY_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 45);
	endfunction

	task automatic put_cmd(input logic [1:0] op, input logic [PAY_W-1:0] pay,
		input logic signed [SCORE_W-1:0] sc, input logic ok);
		int g;
		req.valid       <= 1'b1;
		req.opcode      <= op;
		req.payload     <= pay;
		req.score       <= sc;
		req.score_valid <= ok;
		do @(posedge clk); while (!req.ready);
		n_items++;
		g = pick_gap();
		if (g > 0) begin
			req.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_quiet(input int extra);
		req.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TOL_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// junk above bit 6 of the max_records word must be ignored
	task automatic apply_setting(input logic [MAXREC_W-1:0] m, input logic [TOL_W-1:0] t);
		logic [TOL_W-1:0] d;
		wait_quiet(8);
		d = TOL_W'($urandom);
		d[MAXREC_W-1:0] = m;
		if ($urandom_range(0, 1)) begin
			set_reg(CFG_MAX_RECORDS, d);
			set_reg(CFG_TOLERANCE, t);
		end else begin
			set_reg(CFG_TOLERANCE, t);
			set_reg(CFG_MAX_RECORDS, d);
		end
		n_settings++;
	endtask

	function automatic logic [MAXREC_W-1:0] pick_limit();
		case ($urandom_range(0, 9))
			0: return 7'd0;
			1: return 7'd1;
			2: return 7'd2;
			3: return MAXREC_W'($urandom_range(3, 4));
			4: return MAXREC_W'($urandom_range(5, 8));
			5: return 7'd16;
			6: return 7'd64;
			7: return 7'd127;
			8: return MAXREC_W'($urandom_range(0, 127));
			default: return MAXREC_W'($urandom_range(9, 40));
		endcase
	endfunction

	function automatic logic [TOL_W-1:0] pick_tol();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return TOL_ONE;
			2: return '1;
			3: return TOL_W'(32768);
			4: return TOL_W'(1);
			5: return TOL_W'(65535);
			6: return TOL_W'($urandom_range(0, 131071));
			default: return TOL_W'($urandom_range(3000, 40000));
		endcase
	endfunction

	// most scores sit in [2^(lvl-1), 2^lvl), and lvl rises per phase so the best score climbs
	function automatic logic signed [SCORE_W-1:0] pick_score(input int lvl);
		logic [31:0] lo, hi;
		int r;
		lo = 32'd1 << (lvl - 1);
		hi = (lvl >= 31) ? 32'h7FFF_FFFF : (32'd1 << lvl) - 32'd1;
		r  = $urandom_range(0, 99);
		if (r < 10)
			return last_score;
		if (r < 25)
			return SCORE_W'(hi - $urandom_range(0, 255));
		if (r < 30)
			return SCORE_W'(0 - int'($urandom_range(1, 1048576)));
		if (r < 33)
			return SCORE_W'($urandom);
		return SCORE_W'($urandom_range(hi, lo));
	endfunction

	task automatic put_offer(input int lvl);
		logic signed [SCORE_W-1:0] sc;
		sc = pick_score(lvl);
		last_score = sc;
		put_cmd(OP_OFFER, rand_word(), sc, $urandom_range(0, 19) != 0);
	endtask

	initial begin : stimulus
		int phase, k, r, lvl, walk;
		logic [MAXREC_W-1:0] m;
		logic [TOL_W-1:0] t;
		req.valid       = 1'b0;
		req.opcode      = OP_NOP;
		req.payload     = '0;
		req.score       = '0;
		req.score_valid = 1'b0;
		cfg.valid       = 1'b0;
		cfg.index       = CFG_MAX_RECORDS;
		cfg.data        = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// negative scores only work from an empty store: half tolerance, two slots
		apply_setting(7'd2, TOL_W'(32768));
		put_cmd(OP_READ, rand_word(), $urandom, 1'b1);
		put_cmd(OP_NOP, rand_word(), $urandom, 1'b0);
		put_cmd(OP_REWIND, rand_word(), $urandom, 1'b1);
		put_cmd(OP_OFFER, '1, 32'h7FFF_FFFF, 1'b0);
		put_cmd(OP_OFFER, '0, 32'h8000_0000, 1'b1);
		put_cmd(OP_OFFER, 64'h1111_2222_3333_4444, -32'sd100, 1'b1);
		put_cmd(OP_OFFER, 64'h5555_6666_7777_8888, -32'sd100, 1'b1);
		put_cmd(OP_OFFER, rand_word(), -32'sd120, 1'b1);
		// every held entry falls under the floor and is purged
		put_cmd(OP_OFFER, rand_word(), -32'sd40, 1'b1);
		put_cmd(OP_REWIND, rand_word(), $urandom, 1'b0);
		put_cmd(OP_READ, rand_word(), $urandom, 1'b1);
		put_cmd(OP_READ, rand_word(), $urandom, 1'b1);

		// full tolerance: floor at zero, ties kept in arrival order
		apply_setting(7'd64, TOL_ONE);
		put_cmd(OP_OFFER, rand_word(), -32'sd1, 1'b1);
		put_cmd(OP_OFFER, '1, 32'sd0, 1'b1);
		put_cmd(OP_OFFER, 64'h0123_4567_89AB_CDEF, 32'sh0001_0000, 1'b1);
		put_cmd(OP_OFFER, 64'hFEDC_BA98_7654_3210, 32'sh0001_0000, 1'b1);
		put_cmd(OP_REWIND, rand_word(), $urandom, 1'b1);
		repeat (5) put_cmd(OP_READ, rand_word(), $urandom, 1'b1);

		// limit dropped below the held count
		apply_setting(7'd1, '0);
		put_cmd(OP_OFFER, rand_word(), 32'sh0001_0000, 1'b1);
		put_cmd(OP_REWIND, rand_word(), $urandom, 1'b1);
		put_cmd(OP_READ, rand_word(), $urandom, 1'b1);

		for (phase = 0; phase < PHASES; phase++) begin
			if (phase == 0) begin
				m = '1;
				t = '1;
			end else if (phase == 1) begin
				m = '0;
				t = '0;
			end else begin
				m = pick_limit();
				t = pick_tol();
			end
			apply_setting(m, t);
			lvl  = (phase == PHASES - 1) ? 31 : 17 + phase;
			calm = ($urandom_range(0, 3) == 0);
			k = 0;
			while (k < PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					put_offer(lvl);
					k++;
				end else if (r < 62) begin
					// rewind and walk the list, sometimes past its end
					walk = ($urandom_range(0, 9) == 0) ? 70 : $urandom_range(1, 12);
					put_cmd(OP_REWIND, rand_word(), $urandom, 1'($urandom));
					repeat (walk) put_cmd(OP_READ, rand_word(), $urandom, 1'($urandom));
					k += walk + 1;
				end else if (r < 80) begin
					put_cmd(OP_READ, rand_word(), $urandom, 1'($urandom));
					k++;
				end else if (r < 88) begin
					put_cmd(OP_REWIND, rand_word(), $urandom, 1'($urandom));
					k++;
				end else if (r < 92) begin
					put_cmd(OP_NOP, rand_word(), $urandom, 1'($urandom));
					k++;
				end else begin
					put_cmd(2'($urandom), rand_word(), $urandom, 1'($urandom));
					k++;
				end
			end
		end

		wait_quiet(300);
		$display("summary: %0d commands over %0d register settings, %0d result words checked",
			n_items, n_settings, words_checked);
		$display("summary: %0d offers stored, %0d reads hit, %0d entries purged, %0d dropped",
			offers_kept, reads_hit, purged, dropped);
		if (fails == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> top_k_keeper_with_tolerance_top.f
src/tkk_pkg.sv
src/tkk_if.sv
src/tkk_ram.sv
src/tkk_thresh.sv
src/top_k_keeper_with_tolerance_top.sv
tb/sv/top_k_keeper_with_tolerance_checker.sv
tb/sv/top_k_keeper_with_tolerance_top_test.sv
